>>> sv/uam_pkg.sv
// ----------------------------------------------------------------------------
// uam_pkg
// shared codes, widths and control structs for the adjacency matrix block
// ----------------------------------------------------------------------------
package uam_pkg;

    localparam int VERTEX_W = 5;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;
    localparam int CMD_W    = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SELF  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd3;

    // result kinds driven by the controller
    localparam logic [1:0] EMIT_NONE     = 2'd0;
    localparam logic [1:0] EMIT_STATUS   = 2'd1;
    localparam logic [1:0] EMIT_OK       = 2'd2;
    localparam logic [1:0] EMIT_NEIGHBOR = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic       load;       // latch command fields, read row a
        logic       rd_sel_b;   // read row b
        logic       clear_all;  // drop every row
        logic       wr_a;       // write row a with bit b set
        logic       wr_b;       // write row b with bit a set
        logic       load_scan;  // start a neighbor scan
        logic       step_scan;  // retire the highest neighbor
        logic [1:0] emit;       // result kind
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             oor;
        logic             self_loop;
        logic             dup;
        logic             scan_empty;
        logic             scan_last;
    } t_dp_status;

endpackage

>>> sv/uam_ram.sv
// ----------------------------------------------------------------------------
// uam_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module uam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/uam_ctrl.sv
// ----------------------------------------------------------------------------
// uam_ctrl
// command sequencer: evaluate, mirror write, neighbor scan
// ----------------------------------------------------------------------------
module uam_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    output uam_pkg::t_dp_cmd    o_cmd,
    input  uam_pkg::t_dp_status i_status
);
    import uam_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_WRB  = 2'd2;
    localparam logic [1:0] S_LIST = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_dp_cmd    cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                unique case (i_status.cmd)
                    CMD_CLEAR: begin
                        cmd.clear_all = 1'b1;
                        cmd.emit      = EMIT_OK;
                    end
                    CMD_LIST: begin
                        if (i_status.oor) begin
                            cmd.emit = EMIT_STATUS;
                        end else if (i_status.scan_empty) begin
                            cmd.emit = EMIT_OK;
                        end else begin
                            cmd.load_scan = 1'b1;
                            n_state       = S_LIST;
                        end
                    end
                    CMD_QUERY: begin
                        cmd.emit = EMIT_STATUS;
                    end
                    CMD_ADD: begin
                        if (i_status.oor || i_status.self_loop || i_status.dup) begin
                            cmd.emit = EMIT_STATUS;
                        end else begin
                            cmd.wr_a     = 1'b1;
                            cmd.rd_sel_b = 1'b1;
                            n_state      = S_WRB;
                        end
                    end
                    default: begin
                        cmd.emit = EMIT_STATUS;
                    end
                endcase
            end
            S_WRB: begin
                cmd.wr_b = 1'b1;
                cmd.emit = EMIT_OK;
                n_state  = S_IDLE;
            end
            S_LIST: begin
                cmd.emit      = EMIT_NEIGHBOR;
                cmd.step_scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cmd  = cmd;

    a_start_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_EVAL))
        else $error("accepted command did not enter evaluation");

    a_wrb_after_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRB) |-> ($past(r_state) == S_EVAL))
        else $error("mirror write without a first row write");

    a_list_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST && !i_status.scan_last) |=> (r_state == S_LIST))
        else $error("neighbor scan ended before its last beat");

endmodule

>>> sv/uam_dp.sv
// ----------------------------------------------------------------------------
// uam_dp
// row store, range checks, neighbor scan and result register
// ----------------------------------------------------------------------------
module uam_dp #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  uam_pkg::t_dp_cmd              i_cmd,
    output uam_pkg::t_dp_status           o_status,
    input  logic [uam_pkg::COUNT_W-1:0]   i_vertex_count,
    input  logic [uam_pkg::CMD_W-1:0]     i_command,
    input  logic [uam_pkg::VERTEX_W-1:0]  i_vertex_a,
    input  logic [uam_pkg::VERTEX_W-1:0]  i_vertex_b,
    output logic                          o_strobe,
    output logic [uam_pkg::STATUS_W-1:0]  o_status_code,
    output logic                          o_edge_present,
    output logic [uam_pkg::VERTEX_W-1:0]  o_neighbor_vertex,
    output logic                          o_neighbor_valid,
    output logic                          o_last
);
    import uam_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int VW = (AW > VERTEX_W) ? AW : VERTEX_W;
    localparam int NW = COUNT_W + 1;

    logic [CMD_W-1:0]        r_cmd;
    logic [VERTEX_W-1:0]     r_a;
    logic [VERTEX_W-1:0]     r_b;
    logic [AW-1:0]           r_rd_addr;
    logic [MAX_VERTICES-1:0] r_valid;
    logic [MAX_VERTICES-1:0] r_scan;

    logic                    r_strobe;
    logic [STATUS_W-1:0]     r_status;
    logic                    r_present;
    logic [VERTEX_W-1:0]     r_nbr;
    logic                    r_nbr_valid;
    logic                    r_last;

    logic [VW-1:0]           in_a_ext;
    logic [VW-1:0]           a_ext;
    logic [VW-1:0]           b_ext;
    logic [AW-1:0]           a_addr;
    logic [AW-1:0]           b_addr;
    logic [AW-1:0]           rd_addr;
    logic [MAX_VERTICES-1:0] rd_data;
    logic [MAX_VERTICES-1:0] row_cur;
    logic [NW-1:0]           count_ext;
    logic [NW-1:0]           n_eff;
    logic [MAX_VERTICES-1:0] mask;
    logic [MAX_VERTICES-1:0] bit_a;
    logic [MAX_VERTICES-1:0] bit_b;
    logic [MAX_VERTICES-1:0] top_hot;
    logic [VW-1:0]           top_idx;
    logic                    oor;
    logic                    self_loop;
    logic                    edge_ab;
    logic                    scan_last;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [MAX_VERTICES-1:0] wr_data;
    logic [STATUS_W-1:0]     check_status;

    assign in_a_ext = VW'(i_vertex_a);
    assign a_ext    = VW'(r_a);
    assign b_ext    = VW'(r_b);
    assign a_addr   = a_ext[AW-1:0];
    assign b_addr   = b_ext[AW-1:0];

    // read row a on accept, row b while row a is written back
    assign rd_addr = i_cmd.load ? in_a_ext[AW-1:0] : (i_cmd.rd_sel_b ? b_addr : a_addr);

    uam_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_rows (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // a row never written since reset or clear reads as empty
    assign row_cur = r_valid[r_rd_addr] ? rd_data : '0;

    assign count_ext = NW'(i_vertex_count);
    assign n_eff     = (count_ext > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : count_ext;

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            mask[i]  = (NW'(i) < n_eff);
            bit_a[i] = (a_ext == VW'(i));
            bit_b[i] = (b_ext == VW'(i));
        end
    end

    assign oor       = (NW'(r_a) >= n_eff) || ((r_cmd != CMD_LIST) && (NW'(r_b) >= n_eff));
    assign self_loop = (r_a == r_b);
    assign edge_ab   = |(row_cur & bit_b);

    // highest pending neighbor
    always_comb begin
        top_hot = '0;
        top_idx = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if (r_scan[i]) begin
                top_hot    = '0;
                top_hot[i] = 1'b1;
                top_idx    = VW'(i);
            end
        end
    end

    assign scan_last = ((r_scan & ~top_hot) == '0);

    assign wr_en   = i_cmd.wr_a || i_cmd.wr_b;
    assign wr_addr = i_cmd.wr_b ? b_addr : a_addr;
    assign wr_data = row_cur | (i_cmd.wr_b ? bit_a : bit_b);

    always_comb begin
        if (oor) begin
            check_status = ST_RANGE;
        end else if (r_cmd == CMD_ADD && self_loop) begin
            check_status = ST_SELF;
        end else if (r_cmd == CMD_ADD && edge_ab) begin
            check_status = ST_DUP;
        end else begin
            check_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_a   <= i_vertex_a;
            r_b   <= i_vertex_b;
        end
        r_rd_addr <= rd_addr;
        if (i_cmd.load_scan) begin
            r_scan <= row_cur & mask;
        end else if (i_cmd.step_scan) begin
            r_scan <= r_scan & ~top_hot;
        end
        unique case (i_cmd.emit)
            EMIT_STATUS: begin
                r_status    <= check_status;
                r_present   <= (r_cmd == CMD_QUERY) && !oor && edge_ab;
                r_nbr       <= '0;
                r_nbr_valid <= 1'b0;
                r_last      <= 1'b1;
            end
            EMIT_OK: begin
                r_status    <= ST_OK;
                r_present   <= 1'b0;
                r_nbr       <= '0;
                r_nbr_valid <= 1'b0;
                r_last      <= 1'b1;
            end
            EMIT_NEIGHBOR: begin
                r_status    <= ST_OK;
                r_present   <= 1'b0;
                r_nbr       <= top_idx[VERTEX_W-1:0];
                r_nbr_valid <= 1'b1;
                r_last      <= scan_last;
            end
            EMIT_NONE: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.emit != EMIT_NONE);
            if (i_cmd.clear_all) begin
                r_valid <= '0;
            end else if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    assign o_status.cmd        = r_cmd;
    assign o_status.oor        = oor;
    assign o_status.self_loop  = self_loop;
    assign o_status.dup        = edge_ab;
    assign o_status.scan_empty = ((row_cur & mask) == '0);
    assign o_status.scan_last  = scan_last;

    assign o_strobe          = r_strobe;
    assign o_status_code     = r_status;
    assign o_edge_present    = r_present;
    assign o_neighbor_vertex = r_nbr;
    assign o_neighbor_valid  = r_nbr_valid;
    assign o_last            = r_last;

    a_first_write_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_a |-> (!oor && !self_loop && !edge_ab))
        else $error("row written for an add that failed its checks");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_all |=> (r_valid == '0))
        else $error("clear left a row marked as written");

endmodule

>>> sv/undirected_adjacency_matrix.sv
// ----------------------------------------------------------------------------
// undirected_adjacency_matrix
// symmetric bit matrix graph store with add, query, neighbor listing, clear
// ----------------------------------------------------------------------------
// results: registered at the end of the evaluate state, for a good add at the end
//   of the mirror write state, for a listing from each neighbor scan state
// commands: a new one is accepted only in idle; a good add writes row a and
//   then row b (one row ram port, so the two mirrored rows are written in turn)
// listing: one beat per neighbor, or a single ok beat when the row is empty
// reset: synchronous, clears every row and sets vertex_count to 32
// results go out on o_strobe for one cycle and cannot be stalled
module undirected_adjacency_matrix #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [uam_pkg::CMD_W-1:0]     i_command,
    input  logic [uam_pkg::VERTEX_W-1:0]  i_vertex_a,
    input  logic [uam_pkg::VERTEX_W-1:0]  i_vertex_b,

    // result channel
    output logic                          o_strobe,
    output logic [uam_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_edge_present,
    output logic [uam_pkg::VERTEX_W-1:0]  o_neighbor_vertex,
    output logic                          o_neighbor_valid,
    output logic                          o_last,

    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import uam_pkg::*;

    localparam logic       REG_VERTEX_COUNT = 1'b0;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

    logic [COUNT_W-1:0] r_vertex_count;
    logic               reg_idx;
    logic               wr_strobe;
    t_dp_cmd            dp_cmd;
    t_dp_status         dp_status;

    // register index is the word address, one register at word 0
    assign reg_idx   = paddr[2];
    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= COUNT_RESET;
        end else if (wr_strobe && reg_idx == REG_VERTEX_COUNT) begin
            r_vertex_count <= pwdata[COUNT_W-1:0];
        end
    end

    // reads of unmapped words return zero
    assign prdata = (reg_idx == REG_VERTEX_COUNT) ? 32'(r_vertex_count) : '0;

    // sequencer: idle, evaluate, mirror write, neighbor scan
    uam_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_cmd    (dp_cmd),
        .i_status (dp_status)
    );

    // row ram, checks and result register
    uam_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_status          (dp_status),
        .i_vertex_count    (r_vertex_count),
        .i_command         (i_command),
        .i_vertex_a        (i_vertex_a),
        .i_vertex_b        (i_vertex_b),
        .o_strobe          (o_strobe),
        .o_status_code     (o_status),
        .o_edge_present    (o_edge_present),
        .o_neighbor_vertex (o_neighbor_vertex),
        .o_neighbor_valid  (o_neighbor_valid),
        .o_last            (o_last)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the undirected adjacency matrix: a hand-written table
// of commands with typed answers, then random commands over several vertex
// counts, every result beat checked against a local model of the bit matrix
// ----------------------------------------------------------------------------
module tb;
    import uam_pkg::*;

    localparam int MAX_V             = 32;
    localparam int MAX_REPORTS       = 10;
    localparam int STALL_LIMIT       = 2000;
    localparam int NUM_SEGMENTS      = 7;
    localparam int ITEMS_PER_SEGMENT = 15;
    localparam int NUM_DIRECTED      = 25;

    // register map
    localparam logic [2:0] REG_VERTEX_COUNT = 3'd0;

    // how a table row is checked
    localparam logic CHECK_MODEL = 1'b0;
    localparam logic CHECK_TYPED = 1'b1;

    // sender idle percentage: light, heavy, none
    localparam int IDLE_PLAN [3] = '{15, 53, 0};

    // vertex counts for the random part: small, zero, above max, one, two, mid, full
    localparam logic [COUNT_W-1:0] SEGMENT_COUNTS [NUM_SEGMENTS] =
        '{6'd4, 6'd0, 6'd63, 6'd1, 6'd2, 6'd12, 6'd32};

    // one result beat as it appears on the result ports
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                edge_present;
        logic [VERTEX_W-1:0] neighbor_vertex;
        logic                neighbor_valid;
        logic                last;
    } t_result_beat;

    // one row of the directed table, typed rows give a single expected beat
    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [CMD_W-1:0]    cmd;
        logic [VERTEX_W-1:0] va;
        logic [VERTEX_W-1:0] vb;
        logic                check;
        logic [STATUS_W-1:0] status;
        logic                present;
    } t_stimulus_row;

    localparam t_stimulus_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        // fresh graph after reset
        '{6'd32, CMD_QUERY, 5'd0,  5'd1,  CHECK_TYPED, ST_OK,    1'b0},
        '{6'd32, CMD_LIST,  5'd0,  5'd0,  CHECK_TYPED, ST_OK,    1'b0},
        // extremes of the vertex range, duplicate in mirrored order
        '{6'd32, CMD_ADD,   5'd0,  5'd31, CHECK_TYPED, ST_OK,    1'b0},
        '{6'd32, CMD_ADD,   5'd31, 5'd0,  CHECK_TYPED, ST_DUP,   1'b0},
        '{6'd32, CMD_QUERY, 5'd31, 5'd0,  CHECK_TYPED, ST_OK,    1'b1},
        // self loop on add is an error, on query just answers no
        '{6'd32, CMD_ADD,   5'd5,  5'd5,  CHECK_TYPED, ST_SELF,  1'b0},
        '{6'd32, CMD_QUERY, 5'd5,  5'd5,  CHECK_TYPED, ST_OK,    1'b0},
        '{6'd32, CMD_ADD,   5'd0,  5'd1,  CHECK_MODEL, ST_OK,    1'b0},
        '{6'd32, CMD_ADD,   5'd0,  5'd16, CHECK_MODEL, ST_OK,    1'b0},
        '{6'd32, CMD_ADD,   5'd31, 5'd30, CHECK_MODEL, ST_OK,    1'b0},
        '{6'd32, CMD_LIST,  5'd0,  5'd31, CHECK_MODEL, ST_OK,    1'b0},
        '{6'd32, CMD_ADD,   5'd10, 5'd21, CHECK_MODEL, ST_OK,    1'b0},
        '{6'd32, CMD_ADD,   5'd21, 5'd31, CHECK_MODEL, ST_OK,    1'b0},
        '{6'd32, CMD_LIST,  5'd21, 5'd0,  CHECK_MODEL, ST_OK,    1'b0},
        // clear drops everything
        '{6'd32, CMD_CLEAR, 5'd31, 5'd31, CHECK_TYPED, ST_OK,    1'b0},
        '{6'd32, CMD_LIST,  5'd0,  5'd0,  CHECK_TYPED, ST_OK,    1'b0},
        '{6'd32, CMD_ADD,   5'd2,  5'd29, CHECK_MODEL, ST_OK,    1'b0},
        '{6'd32, CMD_ADD,   5'd29, 5'd30, CHECK_MODEL, ST_OK,    1'b0},
        '{6'd32, CMD_ADD,   5'd3,  5'd2,  CHECK_MODEL, ST_OK,    1'b0},
        // shrunk count hides the high vertices
        '{6'd4,  CMD_ADD,   5'd4,  5'd0,  CHECK_TYPED, ST_RANGE, 1'b0},
        '{6'd4,  CMD_QUERY, 5'd3,  5'd29, CHECK_TYPED, ST_RANGE, 1'b0},
        '{6'd4,  CMD_LIST,  5'd2,  5'd0,  CHECK_MODEL, ST_OK,    1'b0},
        '{6'd4,  CMD_LIST,  5'd29, 5'd0,  CHECK_TYPED, ST_RANGE, 1'b0},
        // count above max acts as max, hidden edges come back
        '{6'd63, CMD_QUERY, 5'd29, 5'd2,  CHECK_TYPED, ST_OK,    1'b1},
        '{6'd63, CMD_LIST,  5'd29, 5'd0,  CHECK_MODEL, ST_OK,    1'b0}
    };

    // dut side signals, the ones the bench drives known from time zero
    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    logic [CMD_W-1:0]    i_command  = CMD_QUERY;
    logic [VERTEX_W-1:0] i_vertex_a = '0;
    logic [VERTEX_W-1:0] i_vertex_b = '0;
    logic                o_strobe;
    logic [STATUS_W-1:0] o_status;
    logic                o_edge_present;
    logic [VERTEX_W-1:0] o_neighbor_vertex;
    logic                o_neighbor_valid;
    logic                o_last;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [2:0]          paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    // model state: full rows are kept, the count only masks what is visible
    logic [MAX_V-1:0]   graph_rows [MAX_V];
    logic [COUNT_W-1:0] vertex_count_shadow = 6'd32;

    // beats still owed by the dut, oldest first
    t_result_beat expected_beats [$];
    t_result_beat seen_beat;
    t_result_beat owed_beat;
    int           error_count  = 0;
    int           stall_cycles = 0;

    undirected_adjacency_matrix #(
        .MAX_VERTICES(MAX_V)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_vertex_a       (i_vertex_a),
        .i_vertex_b       (i_vertex_b),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_edge_present   (o_edge_present),
        .o_neighbor_vertex(o_neighbor_vertex),
        .o_neighbor_valid (o_neighbor_valid),
        .o_last           (o_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result_beat result_beat(input logic [STATUS_W-1:0] status,
                                                 input logic present,
                                                 input logic [VERTEX_W-1:0] nbr,
                                                 input logic valid,
                                                 input logic last);
        t_result_beat beat;
        beat.status          = status;
        beat.edge_present    = present;
        beat.neighbor_vertex = nbr;
        beat.neighbor_valid  = valid;
        beat.last            = last;
        return beat;
    endfunction

    function automatic string beat_text(input t_result_beat beat);
        return $sformatf("status %0d edge %0b neighbor %0d valid %0b last %0b",
                         beat.status, beat.edge_present, beat.neighbor_vertex,
                         beat.neighbor_valid, beat.last);
    endfunction

    // effective vertex count, anything above the matrix size acts as full size
    function automatic int visible_count();
        return (vertex_count_shadow > MAX_V) ? MAX_V : int'(vertex_count_shadow);
    endfunction

    // apply one accepted command to the model and queue the beats it owes
    task automatic predict_graph_command(input logic [CMD_W-1:0] cmd,
                                         input logic [VERTEX_W-1:0] va,
                                         input logic [VERTEX_W-1:0] vb);
        int n;
        int lowest;
        n      = visible_count();
        lowest = -1;
        case (cmd)
            CMD_CLEAR: begin
                foreach (graph_rows[v]) graph_rows[v] = '0;
                expected_beats.push_back(result_beat(ST_OK, 1'b0, '0, 1'b0, 1'b1));
            end
            CMD_LIST: begin
                if (va >= n) begin
                    expected_beats.push_back(result_beat(ST_RANGE, 1'b0, '0, 1'b0, 1'b1));
                end else begin
                    // lowest visible neighbor carries the last flag
                    for (int w = n - 1; w >= 0; w--)
                        if (graph_rows[va][w]) lowest = w;
                    if (lowest < 0) begin
                        expected_beats.push_back(result_beat(ST_OK, 1'b0, '0, 1'b0, 1'b1));
                    end else begin
                        for (int w = n - 1; w >= lowest; w--)
                            if (graph_rows[va][w])
                                expected_beats.push_back(result_beat(ST_OK, 1'b0,
                                    VERTEX_W'(w), 1'b1, w == lowest));
                    end
                end
            end
            CMD_ADD, CMD_QUERY: begin
                if (va >= n || vb >= n) begin
                    expected_beats.push_back(result_beat(ST_RANGE, 1'b0, '0, 1'b0, 1'b1));
                end else if (cmd == CMD_QUERY) begin
                    expected_beats.push_back(result_beat(ST_OK, graph_rows[va][vb],
                                                         '0, 1'b0, 1'b1));
                end else if (va == vb) begin
                    expected_beats.push_back(result_beat(ST_SELF, 1'b0, '0, 1'b0, 1'b1));
                end else if (graph_rows[va][vb]) begin
                    expected_beats.push_back(result_beat(ST_DUP, 1'b0, '0, 1'b0, 1'b1));
                end else begin
                    // both mirrored bits of the new edge
                    graph_rows[va][vb] = 1'b1;
                    graph_rows[vb][va] = 1'b1;
                    expected_beats.push_back(result_beat(ST_OK, 1'b0, '0, 1'b0, 1'b1));
                end
            end
        endcase
    endtask

    // present one command and hold it until the start handshake completes;
    // start stays high into the next command when no gap is drawn
    task automatic issue_command(input logic [CMD_W-1:0] cmd,
                                 input logic [VERTEX_W-1:0] va,
                                 input logic [VERTEX_W-1:0] vb,
                                 input int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_command  <= cmd;
        i_vertex_a <= va;
        i_vertex_b <= vb;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_graph_command(cmd, va, vb);
    endtask

    // mostly in-range vertices so adds land and listings get long,
    // the rest anywhere in the 5-bit field to hit the range check
    function automatic logic [VERTEX_W-1:0] pick_vertex(input int n);
        if (n > 0 && $urandom_range(9) < 8)
            return VERTEX_W'($urandom_range(n - 1));
        return VERTEX_W'($urandom());
    endfunction

    task automatic random_command(input int idle_pct);
        int                  n;
        int                  pick;
        logic [CMD_W-1:0]    cmd;
        logic [VERTEX_W-1:0] va;
        logic [VERTEX_W-1:0] vb;
        n    = visible_count();
        pick = $urandom_range(99);
        if (pick < 45)      cmd = CMD_ADD;
        else if (pick < 70) cmd = CMD_QUERY;
        else if (pick < 95) cmd = CMD_LIST;
        else                cmd = CMD_CLEAR;
        va = pick_vertex(n);
        vb = pick_vertex(n);
        issue_command(cmd, va, vb, idle_pct);
    endtask

    // drop start and wait until every owed beat is out and the block is free
    task automatic wait_until_idle();
        start <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // apb write: setup cycle, then access until pready
    task automatic write_vertex_count(input logic [COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_VERTEX_COUNT;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        vertex_count_shadow = value;
    endtask

    // result checker: every strobe beat is matched against the oldest owed beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            seen_beat = result_beat(o_status, o_edge_present, o_neighbor_vertex,
                                    o_neighbor_valid, o_last);
            if (expected_beats.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected beat at %0t: %s", $realtime, beat_text(seen_beat));
            end else begin
                owed_beat = expected_beats.pop_front();
                if (seen_beat !== owed_beat) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("beat mismatch at %0t: expected %s, got %s", $realtime,
                                 beat_text(owed_beat), beat_text(seen_beat));
                end
            end
        end
    end

    // watchdog: any start handshake or result beat counts as progress
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        foreach (graph_rows[v]) graph_rows[v] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at light sender idling
        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].count != vertex_count_shadow) begin
                wait_until_idle();
                write_vertex_count(DIRECTED_ROWS[r].count);
            end
            issue_command(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].va,
                          DIRECTED_ROWS[r].vb, IDLE_PLAN[0]);
            // typed rows owe exactly one beat, swap in the hand-written one
            if (DIRECTED_ROWS[r].check == CHECK_TYPED) begin
                void'(expected_beats.pop_back());
                expected_beats.push_back(result_beat(DIRECTED_ROWS[r].status,
                                                     DIRECTED_ROWS[r].present,
                                                     '0, 1'b0, 1'b1));
            end
        end

        // random commands, one vertex count per segment, idling light then
        // heavy then off; the matrix carries over so hidden edges resurface
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            wait_until_idle();
            write_vertex_count(SEGMENT_COUNTS[seg]);
            repeat (ITEMS_PER_SEGMENT)
                random_command(IDLE_PLAN[seg * 3 / NUM_SEGMENTS]);
        end

        // drain, then a short quiet window to catch stray beats
        wait_until_idle();
        repeat (40) @(posedge i_clk);
        if (error_count == 0 && expected_beats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/uam_pkg.sv
sv/uam_ram.sv
sv/uam_ctrl.sv
sv/uam_dp.sv
sv/undirected_adjacency_matrix.sv
tb/tb.sv
